// ===== hdl/oahs_pkg.sv =====
// shared types and constants for the open-address hash set
package oahs_pkg;

  localparam int KEY_W  = 64;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 11;  // byte sum of up to eight bytes fits below 2048

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_MEMBER = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_USED    = 2'd1,
    ST_DELETED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FIND
  } fsm_t;

endpackage

// ===== hdl/open_address_hash_set.sv =====
// top level of the open-address hash set with linear probing
//
//   channel  ports                          handshake
//   in       in_opcode, in_key              start high while busy low
//   out      out_success                    out_valid, one cycle, no back pressure
//
// after reset the status memory is swept to empty slot by slot, with busy high.
// an item passes key normalization and home slot reduction in S_HASH, then probes one slot
// per cycle (1 to TABLE_SLOTS, one read port); busy drops together with out_valid, so a
// new item is accepted only once the last one has given its result.
// insert takes its free slot in the same probe pass, so there is no second pass.
// an unused opcode leaves busy low and gives its result in the cycle after acceptance.
module open_address_hash_set import oahs_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BYTES   = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_opcode,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_valid,
  output logic             out_success
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  fsm_t             state_r, state_nxt;
  opcode_t          op_r, op_nxt;
  logic [IDX_W-1:0] h_r, h_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic             free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_success_r, out_success_nxt;

  slot_st_t         stat_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem  [TABLE_SLOTS];
  slot_st_t         stat_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] rd_addr;
  logic             stat_we, key_we;
  logic [IDX_W-1:0] wr_addr;
  slot_st_t         stat_wd;

  logic             hash_start, hash_done;
  logic [IDX_W-1:0] hash_home;
  logic [KEY_W-1:0] key_norm;

  logic             op_ok;
  logic             hit, stop, is_free, free_any;
  logic [IDX_W-1:0] free_sel, h_inc;

  oahs_hash #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .key_raw (in_key),
    .done    (hash_done),
    .home    (hash_home),
    .key_norm(key_norm)
  );

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[wr_addr] <= stat_wd;
    stat_q <= stat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_norm;
    key_q <= key_mem[rd_addr];
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;

  always_comb begin
    case (in_opcode)
      OP_INSERT, OP_DELETE, OP_MEMBER: op_ok = 1'b1;
      default:                         op_ok = 1'b0;
    endcase
  end

  // probe decode for the slot whose data is on the read port
  always_comb begin
    hit      = (stat_q == ST_USED) && (key_q == key_norm);
    stop     = (stat_q == ST_EMPTY) || (n_r == IDX_W'(TABLE_SLOTS - 1));
    is_free  = (stat_q != ST_USED);
    free_any = free_ok_r || is_free;
    free_sel = free_ok_r ? free_r : h_r;
    h_inc    = (h_r == IDX_W'(TABLE_SLOTS - 1)) ? '0 : h_r + 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == IDX_W'(TABLE_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start && op_ok) state_nxt = S_HASH;
      end
      S_HASH: begin
        if (hash_done) state_nxt = S_FIND;
      end
      S_FIND: begin
        if (hit || stop) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt          = op_r;
    h_nxt           = h_r;
    n_nxt           = n_r;
    free_nxt        = free_r;
    free_ok_nxt     = free_ok_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = 1'b0;
    out_success_nxt = out_success_r;
    hash_start      = 1'b0;
    rd_addr         = h_inc;
    stat_we         = 1'b0;
    key_we          = 1'b0;
    wr_addr         = h_r;
    stat_wd         = ST_EMPTY;
    case (state_r)
      S_CLEAR: begin
        stat_we = 1'b1;
        wr_addr = clr_r;
        stat_wd = ST_EMPTY;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt      = opcode_t'(in_opcode);
          n_nxt       = '0;
          free_ok_nxt = 1'b0;
          if (op_ok) begin
            hash_start = 1'b1;
          end else begin
            out_valid_nxt   = 1'b1;
            out_success_nxt = 1'b0;
          end
        end
      end
      S_HASH: begin
        rd_addr = hash_home;
        if (hash_done) h_nxt = hash_home;
      end
      S_FIND: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          case (op_r)
            OP_DELETE: begin
              stat_we         = 1'b1;
              wr_addr         = h_r;
              stat_wd         = ST_DELETED;
              out_success_nxt = 1'b1;
            end
            OP_MEMBER: out_success_nxt = 1'b1;
            default:   out_success_nxt = 1'b0;
          endcase
        end else if (stop) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b0;
          // insert takes the first non-used slot met on the way
          if (op_r == OP_INSERT && free_any) begin
            stat_we         = 1'b1;
            key_we          = 1'b1;
            wr_addr         = free_sel;
            stat_wd         = ST_USED;
            out_success_nxt = 1'b1;
          end
        end else begin
          h_nxt       = h_inc;
          n_nxt       = n_r + 1'b1;
          free_nxt    = free_sel;
          free_ok_nxt = free_any;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      free_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      free_ok_r   <= free_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    h_r           <= h_nxt;
    n_r           <= n_nxt;
    free_r        <= free_nxt;
    out_success_r <= out_success_nxt;
  end

endmodule

// ===== hdl/oahs_hash.sv =====
// key normalization and home slot reduction by reciprocal multiplication
module oahs_hash import oahs_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BYTES   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [KEY_W-1:0]               key_raw,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] home,
  output logic [KEY_W-1:0]               key_norm
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int TS_W   = $clog2(TABLE_SLOTS + 1);
  localparam int DIV_W  = SUM_W + TS_W;
  localparam int PROD_W = 2 * SUM_W;
  // floor of 2^SUM_W over the slot count, so the estimate is at most one below the quotient
  localparam int RECIP  = (1 << SUM_W) / TABLE_SLOTS;

  logic              run_r, run_nxt;
  logic              fin_r, fin_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  norm_key;
  logic [SUM_W-1:0]  norm_sum;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  back;
  logic [DIV_W-1:0]  rem_raw;
  logic [DIV_W-1:0]  rem_fix;

  // cut at first zero byte or after KEY_BYTES bytes
  always_comb begin
    logic       alive;
    logic [7:0] b;
    alive    = 1'b1;
    norm_key = '0;
    norm_sum = '0;
    for (int i = 0; i < KEY_W / BYTE_W; i++) begin
      b = key_raw[i*BYTE_W +: BYTE_W];
      if (i >= KEY_BYTES || b == 8'd0) alive = 1'b0;
      if (alive) begin
        norm_key[i*BYTE_W +: BYTE_W] = b;
        norm_sum = norm_sum + SUM_W'(b);
      end
    end
  end

  // quotient estimate from the sum held since start
  always_comb begin
    prod    = PROD_W'(sum_r) * PROD_W'(RECIP);
    quo_nxt = prod[PROD_W-1:SUM_W];
  end

  // remainder from the estimate, corrected at most once
  always_comb begin
    back    = DIV_W'(quo_r) * DIV_W'(TABLE_SLOTS);
    rem_raw = DIV_W'(sum_r) - back;
    rem_fix = (rem_raw >= DIV_W'(TABLE_SLOTS)) ? rem_raw - DIV_W'(TABLE_SLOTS) : rem_raw;
  end

  assign done     = fin_r;
  assign home     = rem_fix[IDX_W-1:0];
  assign key_norm = key_r;

  always_comb begin
    run_nxt = start;
    fin_nxt = run_r;
    sum_nxt = start ? norm_sum : sum_r;
    key_nxt = start ? norm_key : key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    quo_r <= quo_nxt;
    key_r <= key_nxt;
  end

endmodule
